### rtl/block_basis_congruence_transform_macros.svh
// Assertion macros for the block basis congruence transform.
// Included by the top level; expects clk and rst_n in scope.
`ifndef BLOCK_BASIS_CONGRUENCE_TRANSFORM_MACROS_SVH
`define BLOCK_BASIS_CONGRUENCE_TRANSFORM_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BBCT_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("bbct assertion failed");

// Next-cycle implication, checked outside reset.
`define BBCT_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("bbct assertion failed");

`endif

### rtl/bbct_pkg.sv
// Shared types and constants of the block basis congruence transform.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package bbct_pkg;

  // Parameter defaults.
  localparam int MAX_LARGE_DEF  = 16;
  localparam int MAX_SMALL_DEF  = 16;
  localparam int PART_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Loop indices cover the full parameter range (order up to 128).
  localparam int IDX_W = 7;

  localparam int COUNT_W   = 5;
  localparam int CFG_IDX_W = 1;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LARGE_COUNT = 1'b0,
    CFG_SMALL_COUNT = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OP_WRITE_H = 2'd0,
    OP_WRITE_C = 2'd1,
    OP_COMPUTE = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic             accept;
    logic             rd_en;
    logic             mul_en;
    logic             cmb_en;
    logic             acc_en;
    logic             phase;
    logic             unit;
    logic             first;
    logic             last;
    logic [IDX_W-1:0] m_row;
    logic [IDX_W-1:0] m_col;
    logic [IDX_W-1:0] c_row;
    logic [IDX_W-1:0] c_col;
    logic [IDX_W-1:0] w_row;
    logic [IDX_W-1:0] w_col;
  } seq_cmd_t;

endpackage

`default_nettype wire

### rtl/bbct_ctrl.sv
// Controller: request handshake and the compute loop sequencer.
// Depends on bbct_pkg for the command struct and operation codes.
`default_nettype none

module bbct_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  in_operation,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  input  wire logic [bbct_pkg::IDX_W-1:0]  eff_large,
  input  wire logic [bbct_pkg::IDX_W-1:0]  eff_small,
  output bbct_pkg::seq_cmd_t               cmd
);

  typedef enum logic [2:0] {ST_IDLE, ST_RD, ST_MUL, ST_CMB, ST_ACC} state_t;

  state_t                      state_r, state_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        phase_r, phase_nxt;
  logic [bbct_pkg::IDX_W-1:0]  row_r, row_nxt, col_r, col_nxt, k_r, k_nxt;
  logic                        accept, unit, last;
  logic [bbct_pkg::IDX_W-1:0]  l_plus_k, row_last, col_last;

  assign in_ready  = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    l_plus_k = eff_large + k_r;
    unit     = phase_r ? (row_r < eff_large) : (col_r < eff_large);
    last     = unit || (k_r == eff_small - 1'b1);
    col_last = (eff_large << 1) - 1'b1;
    row_last = phase_r ? col_last : eff_large + eff_small - 1'b1;

    cmd        = '0;
    cmd.accept = accept;
    cmd.rd_en  = (state_r == ST_RD);
    cmd.mul_en = (state_r == ST_MUL);
    cmd.cmb_en = (state_r == ST_CMB);
    cmd.acc_en = (state_r == ST_ACC);
    cmd.phase  = phase_r;
    cmd.unit   = unit;
    cmd.first  = (k_r == '0);
    cmd.last   = last;
    cmd.c_col  = k_r;
    cmd.w_row  = row_r;
    cmd.w_col  = col_r;
    if (phase_r) begin
      cmd.m_row = unit ? row_r : l_plus_k;
      cmd.m_col = col_r;
      cmd.c_row = row_r - eff_large;
    end else begin
      cmd.m_row = row_r;
      cmd.m_col = unit ? col_r : l_plus_k;
      cmd.c_row = col_r - eff_large;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    k_nxt         = k_r;
    out_valid_nxt = accept ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
    case (state_r)
      ST_IDLE: begin
        if (accept && (bbct_pkg::op_t'(in_operation) == bbct_pkg::OP_COMPUTE)) begin
          state_nxt = ST_RD;
          phase_nxt = 1'b0;
          row_nxt   = '0;
          col_nxt   = '0;
          k_nxt     = '0;
        end
      end
      ST_RD:  state_nxt = ST_MUL;
      ST_MUL: state_nxt = ST_CMB;
      ST_CMB: state_nxt = ST_ACC;
      ST_ACC: begin
        state_nxt = ST_RD;
        if (!last) begin
          k_nxt = k_r + 1'b1;
        end else begin
          k_nxt = '0;
          if (col_r == col_last) begin
            col_nxt = '0;
            if (row_r == row_last) begin
              row_nxt = '0;
              if (phase_r) begin
                state_nxt = ST_IDLE;
              end else begin
                phase_nxt = 1'b1;
              end
            end else begin
              row_nxt = row_r + 1'b1;
            end
          end else begin
            col_nxt = col_r + 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
      row_r       <= '0;
      col_r       <= '0;
      k_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      k_r         <= k_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/bbct_datapath.sv
// Datapath: matrix stores, complex multiply-accumulate and result register.
// Depends on bbct_pkg; driven by commands from bbct_ctrl.
`default_nettype none

module bbct_datapath #(
  parameter int MAX_LARGE  = bbct_pkg::MAX_LARGE_DEF,
  parameter int MAX_SMALL  = bbct_pkg::MAX_SMALL_DEF,
  parameter int PART_WIDTH = bbct_pkg::PART_WIDTH_DEF,
  parameter int FRAC_BITS  = bbct_pkg::FRAC_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire bbct_pkg::seq_cmd_t          cmd,
  input  wire logic [1:0]                  in_operation,
  input  wire logic [4:0]                  in_row_index,
  input  wire logic [4:0]                  in_col_index,
  input  wire logic signed [31:0]          in_value_real,
  input  wire logic signed [31:0]          in_value_imag,
  input  wire logic [bbct_pkg::IDX_W-1:0]  eff_large,
  input  wire logic [bbct_pkg::IDX_W-1:0]  eff_small,
  output logic signed [31:0]               out_result_real,
  output logic signed [31:0]               out_result_imag,
  output logic                             out_status
);

  localparam int PW   = PART_WIDTH;
  localparam int WIDE = 2 * PW + 2;
  localparam int HDIM = MAX_LARGE + MAX_SMALL;
  localparam int RDIM = 2 * MAX_LARGE;
  localparam int HDEP = HDIM * HDIM;
  localparam int CDEP = MAX_LARGE * MAX_SMALL;
  localparam int PDEP = HDIM * RDIM;
  localparam int RDEP = RDIM * RDIM;
  localparam int HAW  = $clog2(HDEP);
  localparam int CAW  = (CDEP > 1) ? $clog2(CDEP) : 1;
  localparam int PAW  = $clog2(PDEP);
  localparam int RAW  = $clog2(RDEP);
  localparam int XW   = bbct_pkg::IDX_W + 1;

  localparam logic signed [WIDE-1:0] SAT_HI = {{(WIDE-PW+1){1'b0}}, {(PW-1){1'b1}}};
  localparam logic signed [WIDE-1:0] SAT_LO = ~SAT_HI;
  localparam logic signed [WIDE-1:0] ONE_W  = WIDE'(1) <<< FRAC_BITS;
  localparam logic signed [PW-1:0]   ONE_RE = (ONE_W > SAT_HI) ? PW'(SAT_HI) : PW'(ONE_W);

  typedef struct packed {
    logic signed [PW-1:0] re;
    logic signed [PW-1:0] im;
  } cval_t;

  function automatic logic signed [PW-1:0] sat_w(input logic signed [WIDE-1:0] v);
    logic signed [PW-1:0] r;
    if (v > SAT_HI) r = PW'(SAT_HI);
    else if (v < SAT_LO) r = PW'(SAT_LO);
    else r = PW'(v);
    return r;
  endfunction

  function automatic logic signed [PW-1:0] fmul(input logic signed [PW-1:0] x,
                                                input logic signed [PW-1:0] y);
    logic signed [WIDE-1:0] p;
    p = WIDE'(x) * WIDE'(y);
    return sat_w(p >>> FRAC_BITS);
  endfunction

  cval_t h_mem_r [HDEP];
  cval_t c_mem_r [CDEP];
  cval_t p_mem_r [PDEP];
  cval_t r_mem_r [RDEP];

  cval_t h_q_r, c_q_r, p_q_r, r_q_r;
  cval_t wval, op_a, op_b, acc_r, acc_nxt, base;
  logic signed [PW-1:0] m_ac_r, m_bd_r, m_ad_r, m_bc_r, t_re_r, t_im_r;
  logic                 status_r, hit_r;
  logic [XW-1:0]        row_x, col_x, l_x, s_x, n_x, l2_x;
  logic                 h_ok, c_ok, r_ok;
  bbct_pkg::op_t        op;

  assign op = bbct_pkg::op_t'(in_operation);

  always_comb begin
    wval.re = sat_w(WIDE'(in_value_real));
    wval.im = sat_w(WIDE'(in_value_imag));
    row_x   = XW'(in_row_index);
    col_x   = XW'(in_col_index);
    l_x     = XW'(eff_large);
    s_x     = XW'(eff_small);
    n_x     = l_x + s_x;
    l2_x    = l_x << 1;
    h_ok    = (row_x < n_x) && (col_x < n_x);
    c_ok    = (row_x < l_x) && (col_x < s_x);
    r_ok    = (row_x < l2_x) && (col_x < l2_x);
  end

  // Loads and reads from the request channel.
  always_ff @(posedge clk) begin
    if (cmd.accept && (op == bbct_pkg::OP_WRITE_H) && h_ok) begin
      h_mem_r[HAW'(in_row_index * HDIM + in_col_index)] <= wval;
    end
    if (cmd.accept && (op == bbct_pkg::OP_WRITE_C) && c_ok) begin
      c_mem_r[CAW'(in_row_index * MAX_SMALL + in_col_index)] <= wval;
    end
    if (cmd.accept && (op == bbct_pkg::OP_READ)) begin
      r_q_r <= r_mem_r[RAW'(in_row_index * RDIM + in_col_index)];
    end
    if (cmd.accept) begin
      hit_r <= (op == bbct_pkg::OP_READ) && r_ok;
      case (op)
        bbct_pkg::OP_WRITE_H: status_r <= h_ok ? bbct_pkg::STATUS_OK : bbct_pkg::STATUS_RANGE;
        bbct_pkg::OP_WRITE_C: status_r <= c_ok ? bbct_pkg::STATUS_OK : bbct_pkg::STATUS_RANGE;
        bbct_pkg::OP_READ:    status_r <= r_ok ? bbct_pkg::STATUS_OK : bbct_pkg::STATUS_RANGE;
        default:              status_r <= bbct_pkg::STATUS_OK;
      endcase
    end
  end

  // Operand fetch for one product term.
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      h_q_r <= h_mem_r[HAW'(cmd.m_row * HDIM + cmd.m_col)];
      p_q_r <= p_mem_r[PAW'(cmd.m_row * RDIM + cmd.m_col)];
      c_q_r <= c_mem_r[CAW'(cmd.c_row * MAX_SMALL + cmd.c_col)];
    end
  end

  always_comb begin
    if (cmd.phase) begin
      op_a.re = cmd.unit ? ONE_RE : c_q_r.re;
      op_a.im = cmd.unit ? '0 : sat_w(-WIDE'(c_q_r.im));
      op_b    = p_q_r;
    end else begin
      op_a    = h_q_r;
      op_b.re = cmd.unit ? ONE_RE : c_q_r.re;
      op_b.im = cmd.unit ? '0 : c_q_r.im;
    end
    base       = cmd.first ? '0 : acc_r;
    acc_nxt.re = sat_w(WIDE'(base.re) + WIDE'(t_re_r));
    acc_nxt.im = sat_w(WIDE'(base.im) + WIDE'(t_im_r));
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      m_ac_r <= fmul(op_a.re, op_b.re);
      m_bd_r <= fmul(op_a.im, op_b.im);
      m_ad_r <= fmul(op_a.re, op_b.im);
      m_bc_r <= fmul(op_a.im, op_b.re);
    end
    if (cmd.cmb_en) begin
      t_re_r <= sat_w(WIDE'(m_ac_r) - WIDE'(m_bd_r));
      t_im_r <= sat_w(WIDE'(m_ad_r) + WIDE'(m_bc_r));
    end
    if (cmd.acc_en) begin
      acc_r <= acc_nxt;
      if (cmd.last && !cmd.phase) begin
        p_mem_r[PAW'(cmd.w_row * RDIM + cmd.w_col)] <= acc_nxt;
      end
      if (cmd.last && cmd.phase) begin
        r_mem_r[RAW'(cmd.w_row * RDIM + cmd.w_col)] <= acc_nxt;
      end
    end
  end

  assign out_result_real = hit_r ? 32'(r_q_r.re) : '0;
  assign out_result_imag = hit_r ? 32'(r_q_r.im) : '0;
  assign out_status      = status_r;

endmodule

`default_nettype wire

### rtl/block_basis_congruence_transform.sv
// Loads, reads and configuration: one request per cycle while the output is not
// held; result next cycle. Compute: one product term at a time on one shared
// complex multiply-accumulate, (L+S)*L*(1+S) + 2*L*L*(1+S) terms in all, the
// input stalls meanwhile. Synchronous active-low reset clears the handshake, the
// sequencer and sets both counts to 16; matrix stores hold garbage until written.
`default_nettype none

module block_basis_congruence_transform #(
  parameter int MAX_LARGE  = bbct_pkg::MAX_LARGE_DEF,
  parameter int MAX_SMALL  = bbct_pkg::MAX_SMALL_DEF,
  parameter int PART_WIDTH = bbct_pkg::PART_WIDTH_DEF,
  parameter int FRAC_BITS  = bbct_pkg::FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [1:0]                        in_operation,
  input  wire logic [4:0]                        in_row_index,
  input  wire logic [4:0]                        in_col_index,
  input  wire logic signed [31:0]                in_value_real,
  input  wire logic signed [31:0]                in_value_imag,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [31:0]                     out_result_real,
  output logic signed [31:0]                     out_result_imag,
  output logic                                   out_status,
  input  wire logic                              cfg_wr_en,
  input  wire logic [bbct_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [bbct_pkg::COUNT_W-1:0]      cfg_data
);

  `include "block_basis_congruence_transform_macros.svh"

  // Configuration registers hold the raw written counts.
  logic [bbct_pkg::COUNT_W-1:0] large_count_r, small_count_r;
  logic [bbct_pkg::IDX_W-1:0]   eff_large, eff_small;
  bbct_pkg::seq_cmd_t           cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      large_count_r <= bbct_pkg::COUNT_RESET;
      small_count_r <= bbct_pkg::COUNT_RESET;
    end else if (cfg_wr_en) begin
      case (bbct_pkg::cfg_reg_t'(cfg_index))
        bbct_pkg::CFG_LARGE_COUNT: large_count_r <= cfg_data;
        bbct_pkg::CFG_SMALL_COUNT: small_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // A count of zero acts as one; a count above the maximum acts as the maximum.
  always_comb begin
    if (large_count_r == '0) begin
      eff_large = bbct_pkg::IDX_W'(1);
    end else if (bbct_pkg::IDX_W'(large_count_r) > bbct_pkg::IDX_W'(MAX_LARGE)) begin
      eff_large = bbct_pkg::IDX_W'(MAX_LARGE);
    end else begin
      eff_large = bbct_pkg::IDX_W'(large_count_r);
    end
    if (small_count_r == '0) begin
      eff_small = bbct_pkg::IDX_W'(1);
    end else if (bbct_pkg::IDX_W'(small_count_r) > bbct_pkg::IDX_W'(MAX_SMALL)) begin
      eff_small = bbct_pkg::IDX_W'(MAX_SMALL);
    end else begin
      eff_small = bbct_pkg::IDX_W'(small_count_r);
    end
  end

  // The controller owns the handshake and walks the two product loops.
  bbct_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .eff_large    (eff_large),
    .eff_small    (eff_small),
    .cmd          (cmd)
  );

  // The datapath holds the four stores and the multiply-accumulate unit.
  bbct_datapath #(
    .MAX_LARGE  (MAX_LARGE),
    .MAX_SMALL  (MAX_SMALL),
    .PART_WIDTH (PART_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk             (clk),
    .cmd             (cmd),
    .in_operation    (in_operation),
    .in_row_index    (in_row_index),
    .in_col_index    (in_col_index),
    .in_value_real   (in_value_real),
    .in_value_imag   (in_value_imag),
    .eff_large       (eff_large),
    .eff_small       (eff_small),
    .out_result_real (out_result_real),
    .out_result_imag (out_result_imag),
    .out_status      (out_status)
  );

  // Every accepted request produces a result in the next cycle.
  `BBCT_ASSERT_NEXT(a_result_follows, in_valid && in_ready, out_valid)
  // A compute request locks out the input while the loops run.
  `BBCT_ASSERT_NEXT(a_compute_stalls,
    in_valid && in_ready && (in_operation == bbct_pkg::OP_COMPUTE), !in_ready)
  // A compute request answers with an accepted status and zero data.
  `BBCT_ASSERT_NEXT(a_compute_result,
    in_valid && in_ready && (in_operation == bbct_pkg::OP_COMPUTE),
    (out_status == bbct_pkg::STATUS_OK) && (out_result_real == 32'sd0))
  // An out-of-range status never carries data.
  `BBCT_ASSERT_NOW(a_error_zero, out_valid && (out_status == bbct_pkg::STATUS_RANGE),
    (out_result_real == 32'sd0) && (out_result_imag == 32'sd0))

endmodule

`default_nettype wire

### bench/tb_top.sv
// Self-checking bench for block_basis_congruence_transform: loads H and C,
// computes, reads back, and compares every reply against an internal predictor.
// Depends on bbct_pkg and the block's RTL only.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HDIM = 32;
  localparam int RDIM = 32;
  localparam int NMAX = 16;
  localparam int CYCLE_LIMIT = 600000;
  localparam int LONG_HOLD = 400;

  typedef struct {
    longint re;
    longint im;
  } cplx_t;

  typedef struct {
    bbct_pkg::op_t      op;
    logic [4:0]         row;
    logic [4:0]         col;
    logic signed [31:0] vr;
    logic signed [31:0] vi;
  } request_t;

  typedef struct {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic               status;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_operation = '0;
  logic [4:0] in_row_index = '0;
  logic [4:0] in_col_index = '0;
  logic signed [31:0] in_value_real = '0;
  logic signed [31:0] in_value_imag = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_result_real;
  logic signed [31:0] out_result_imag;
  logic out_status;
  logic cfg_wr_en = 1'b0;
  logic [bbct_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bbct_pkg::COUNT_W-1:0] cfg_data = '0;

  block_basis_congruence_transform dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_operation(in_operation), .in_row_index(in_row_index),
    .in_col_index(in_col_index), .in_value_real(in_value_real),
    .in_value_imag(in_value_imag),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_result_real(out_result_real), .out_result_imag(out_result_imag),
    .out_status(out_status),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Requests waiting to be driven, and the replies the predictor expects.
  request_t pending_requests[$];
  reply_t   expected_replies[$];

  // Predictor state: the raw count registers and the four matrix stores.
  logic [4:0] large_raw = 5'd16;
  logic [4:0] small_raw = 5'd16;
  cplx_t h_mat[HDIM][HDIM];
  cplx_t c_mat[NMAX][NMAX];
  cplx_t part_mat[HDIM][RDIM];
  cplx_t res_mat[RDIM][RDIM];

  // Bookkeeping of the stimulus side, so that no unwritten entry is ever used.
  bit h_known[HDIM][HDIM];
  bit c_known[NMAX][NMAX];
  bit r_known[RDIM][RDIM];

  int error_count = 0;
  int reply_count = 0;
  int request_count = 0;
  int compute_count = 0;
  int range_error_count = 0;
  int cycle_count = 0;

  // ---------------------------------------------------------------------
  // Fixed-point arithmetic of the block: 32-bit parts with 16 fraction bits.
  // ---------------------------------------------------------------------
  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Products keep every bit, then drop the fraction by flooring.
  function automatic longint fx_mul(longint x, longint y);
    longint p;
    p = x * y;
    return clip32(p >>> 16);
  endfunction

  function automatic cplx_t cx_mul(cplx_t a, cplx_t b);
    cplx_t r;
    r.re = clip32(fx_mul(a.re, b.re) - fx_mul(a.im, b.im));
    r.im = clip32(fx_mul(a.re, b.im) + fx_mul(a.im, b.re));
    return r;
  endfunction

  function automatic cplx_t cx_add(cplx_t a, cplx_t b);
    cplx_t r;
    r.re = clip32(a.re + b.re);
    r.im = clip32(a.im + b.im);
    return r;
  endfunction

  function automatic cplx_t cx_conj(cplx_t a);
    a.im = clip32(-a.im);
    return a;
  endfunction

  // A count of zero behaves as one; anything above sixteen as sixteen.
  function automatic int eff_count(logic [4:0] raw);
    if (raw == 0) return 1;
    if (raw > NMAX) return NMAX;
    return int'(raw);
  endfunction

  // Forms H*W into the partial store, then W^H * (H*W) into the result store.
  task automatic congruence_transform(int nl, int ns);
    cplx_t one, zero, acc;
    one.re = 64'sd65536;
    one.im = 0;
    zero.re = 0;
    zero.im = 0;
    for (int r = 0; r < nl + ns; r++) begin
      for (int j = 0; j < nl; j++)
        part_mat[r][j] = cx_add(zero, cx_mul(h_mat[r][j], one));
      for (int j = 0; j < nl; j++) begin
        acc = zero;
        for (int i = 0; i < ns; i++)
          acc = cx_add(acc, cx_mul(h_mat[r][nl+i], c_mat[j][i]));
        part_mat[r][nl+j] = acc;
      end
    end
    for (int j = 0; j < nl; j++)
      for (int b = 0; b < 2 * nl; b++)
        res_mat[j][b] = cx_add(zero, cx_mul(cx_conj(one), part_mat[j][b]));
    for (int j = 0; j < nl; j++)
      for (int b = 0; b < 2 * nl; b++) begin
        acc = zero;
        for (int i = 0; i < ns; i++)
          acc = cx_add(acc, cx_mul(cx_conj(c_mat[j][i]), part_mat[nl+i][b]));
        res_mat[nl+j][b] = acc;
      end
  endtask

  // Applies one accepted request to the predictor and queues its reply.
  task automatic predict_reply(request_t q);
    int nl, ns;
    cplx_t v;
    reply_t e;
    nl = eff_count(large_raw);
    ns = eff_count(small_raw);
    v.re = longint'(q.vr);
    v.im = longint'(q.vi);
    e.re = '0;
    e.im = '0;
    e.status = bbct_pkg::STATUS_OK;
    case (q.op)
      bbct_pkg::OP_WRITE_H: begin
        if (q.row < nl + ns && q.col < nl + ns) h_mat[q.row][q.col] = v;
        else e.status = bbct_pkg::STATUS_RANGE;
      end
      bbct_pkg::OP_WRITE_C: begin
        if (q.row < nl && q.col < ns) c_mat[q.row][q.col] = v;
        else e.status = bbct_pkg::STATUS_RANGE;
      end
      bbct_pkg::OP_COMPUTE: begin
        congruence_transform(nl, ns);
      end
      default: begin
        if (q.row < 2 * nl && q.col < 2 * nl) begin
          e.re = res_mat[q.row][q.col].re[31:0];
          e.im = res_mat[q.row][q.col].im[31:0];
        end else begin
          e.status = bbct_pkg::STATUS_RANGE;
        end
      end
    endcase
    expected_replies.push_back(e);
  endtask

  task automatic report(string what, longint got, longint want);
    error_count++;
    $display("MISMATCH at cycle %0d, reply %0d: %s got %0d expected %0d",
             cycle_count, reply_count, what, got, want);
  endtask

  // ---------------------------------------------------------------------
  // Sender: drives requests from the pending queue in bursts with gaps.
  // Bookkeeping counters here are private to this process.
  // ---------------------------------------------------------------------
  request_t drv_req;
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_reply(drv_req);
        request_count++;
      end
      // A new request may only be placed once the current one is gone.
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          drv_req = pending_requests.pop_front();
          in_operation <= drv_req.op;
          in_row_index <= drv_req.row;
          in_col_index <= drv_req.col;
          in_value_real <= drv_req.vr;
          in_value_imag <= drv_req.vi;
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            // Start the next burst; about a third of the time with no gap at all.
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: stalls on its own pattern, switching at random between calm stretches
  // with no stalls and stretches of moderate or heavy random back-pressure.
  // ---------------------------------------------------------------------
  bit want_long_hold = 1'b0;
  bit long_hold_done = 1'b0;
  int hold_left = 0;
  int mode_left = 0;
  int stall_pct = 0;

  // The long hold-off is counted here, apart from the normal stall pattern.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (want_long_hold && !long_hold_done) begin
      hold_left <= LONG_HOLD;
      long_hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (mode_left == 0) begin
      mode_left = $urandom_range(20, 150);
      case ($urandom_range(0, 2))
        0: stall_pct = 0;
        1: stall_pct = 30;
        default: stall_pct = 75;
      endcase
    end else begin
      mode_left--;
    end
    if (hold_left > 0) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Monitor: each accepted reply is checked against the oldest expectation.
  always @(posedge clk) begin
    reply_t e;
    if (rst_n && out_valid && out_ready) begin
      reply_count++;
      if (expected_replies.size() == 0) begin
        report("unexpected reply, status", out_status, 0);
      end else begin
        e = expected_replies.pop_front();
        if (e.status == bbct_pkg::STATUS_RANGE) range_error_count++;
        if (out_status !== e.status) report("status", out_status, e.status);
        if (out_result_real !== e.re) report("result_real", out_result_real, e.re);
        if (out_result_imag !== e.im) report("result_imag", out_result_imag, e.im);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d replies outstanding",
               cycle_count, expected_replies.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------

  // Mostly moderate values so that sums stay meaningful, with the extremes
  // and full-range values mixed in so that every bit toggles.
  function automatic logic signed [31:0] pick_part();
    case ($urandom_range(0, 15))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sd0;
      3: return 32'sd65536;
      4: return -32'sd65536;
      5: return $urandom();
      default: return $signed($urandom_range(0, 32'h7ffff)) - 32'sh40000;
    endcase
  endfunction

  function automatic request_t make_req(bbct_pkg::op_t op, int row, int col);
    request_t q;
    q.op = op;
    q.row = row[4:0];
    q.col = col[4:0];
    q.vr = pick_part();
    q.vi = pick_part();
    return q;
  endfunction

  // Queues a request and mirrors its effect on the known-entry maps.
  task automatic queue_req(request_t q);
    int nl, ns;
    nl = eff_count(large_raw);
    ns = eff_count(small_raw);
    if (q.op == bbct_pkg::OP_WRITE_H && q.row < nl + ns && q.col < nl + ns)
      h_known[q.row][q.col] = 1'b1;
    if (q.op == bbct_pkg::OP_WRITE_C && q.row < nl && q.col < ns)
      c_known[q.row][q.col] = 1'b1;
    if (q.op == bbct_pkg::OP_COMPUTE) begin
      compute_count++;
      for (int r = 0; r < 2 * nl; r++)
        for (int c = 0; c < 2 * nl; c++) r_known[r][c] = 1'b1;
    end
    pending_requests.push_back(q);
  endtask

  // Waits until every request has been answered and any compute has finished,
  // then lets the block settle.
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_requests.size() != 0 || in_valid || expected_replies.size() != 0);
    while (!in_ready) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(bbct_pkg::cfg_reg_t idx, logic [4:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == bbct_pkg::CFG_LARGE_COUNT) large_raw = val;
    else small_raw = val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // One phase: set both counts, load whatever the compute will need, compute,
  // then a random mix of loads, reads, bad indices and recomputes.
  task automatic run_phase(logic [4:0] lraw, logic [4:0] sraw, int mix);
    int nl, ns, n, pick, r, c;
    wait_drained();
    write_reg(bbct_pkg::CFG_LARGE_COUNT, lraw);
    write_reg(bbct_pkg::CFG_SMALL_COUNT, sraw);
    nl = eff_count(large_raw);
    ns = eff_count(small_raw);
    n = nl + ns;
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        if (!h_known[i][j] || $urandom_range(0, 9) == 0)
          queue_req(make_req(bbct_pkg::OP_WRITE_H, i, j));
    for (int i = 0; i < nl; i++)
      for (int j = 0; j < ns; j++)
        if (!c_known[i][j] || $urandom_range(0, 3) == 0)
          queue_req(make_req(bbct_pkg::OP_WRITE_C, i, j));
    queue_req(make_req(bbct_pkg::OP_COMPUTE, $urandom_range(0, 31), $urandom_range(0, 31)));
    for (int k = 0; k < mix; k++) begin
      pick = $urandom_range(0, 99);
      r = $urandom_range(0, 31);
      c = $urandom_range(0, 31);
      if (pick < 25) begin
        queue_req(make_req(bbct_pkg::OP_WRITE_H, $urandom_range(0, n - 1),
                           $urandom_range(0, n - 1)));
      end else if (pick < 35) begin
        queue_req(make_req(bbct_pkg::OP_WRITE_C, $urandom_range(0, nl - 1),
                           $urandom_range(0, ns - 1)));
      end else if (pick < 45) begin
        // Any index at all; out-of-range ones must come back flagged.
        queue_req(make_req(($urandom_range(0, 1) == 0) ? bbct_pkg::OP_WRITE_H
                                                       : bbct_pkg::OP_WRITE_C, r, c));
      end else if (pick < 95) begin
        if ($urandom_range(0, 4) != 0 || (r < 2 * nl && c < 2 * nl && !r_known[r][c])) begin
          r = $urandom_range(0, 2 * nl - 1);
          c = $urandom_range(0, 2 * nl - 1);
        end
        queue_req(make_req(bbct_pkg::OP_READ, r, c));
      end else begin
        queue_req(make_req(bbct_pkg::OP_COMPUTE, r, c));
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------
  initial begin
    request_t q;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: smallest matrices with extreme values, a count of zero,
    // bad indices on every operation, a compute carrying junk indices,
    // and reads of every result entry plus the far corner.
    write_reg(bbct_pkg::CFG_LARGE_COUNT, 5'd0);
    write_reg(bbct_pkg::CFG_SMALL_COUNT, 5'd1);
    q = make_req(bbct_pkg::OP_WRITE_H, 0, 0);
    q.vr = 32'sh7fffffff; q.vi = 32'sh80000000; queue_req(q);
    q = make_req(bbct_pkg::OP_WRITE_H, 0, 1);
    q.vr = 32'sh80000000; q.vi = 32'sh7fffffff; queue_req(q);
    q = make_req(bbct_pkg::OP_WRITE_H, 1, 0);
    q.vr = 32'sd65536;    q.vi = -32'sd1;       queue_req(q);
    q = make_req(bbct_pkg::OP_WRITE_H, 1, 1);
    q.vr = 32'sd0;        q.vi = 32'sd0;        queue_req(q);
    q = make_req(bbct_pkg::OP_WRITE_C, 0, 0);
    q.vr = 32'sh80000000; q.vi = 32'sh80000000; queue_req(q);
    queue_req(make_req(bbct_pkg::OP_WRITE_H, 2, 0));
    queue_req(make_req(bbct_pkg::OP_WRITE_H, 0, 31));
    queue_req(make_req(bbct_pkg::OP_WRITE_C, 1, 0));
    queue_req(make_req(bbct_pkg::OP_WRITE_C, 0, 31));
    q = make_req(bbct_pkg::OP_COMPUTE, 31, 31);
    q.vr = 32'shffffffff; q.vi = 32'shffffffff; queue_req(q);
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++) queue_req(make_req(bbct_pkg::OP_READ, i, j));
    queue_req(make_req(bbct_pkg::OP_READ, 31, 31));
    queue_req(make_req(bbct_pkg::OP_READ, 2, 0));
    queue_req(make_req(bbct_pkg::OP_READ, 0, 2));
    q = make_req(bbct_pkg::OP_WRITE_C, 0, 0); q.vr = 32'sd65536; q.vi = 32'sd0; queue_req(q);
    queue_req(make_req(bbct_pkg::OP_COMPUTE, 0, 0));
    queue_req(make_req(bbct_pkg::OP_READ, 1, 1));
    queue_req(make_req(bbct_pkg::OP_READ, 0, 1));

    // Random phases across several count settings, extremes included:
    // raw values above sixteen clamp, and zero counts as one.
    run_phase(5'd2, 5'd3, 40);
    run_phase(5'd31, 5'd1, 30);
    want_long_hold = 1'b1;
    run_phase(5'd1, 5'd31, 40);
    run_phase(5'd3, 5'd0, 40);
    run_phase(5'd5, 5'd4, 50);
    run_phase(5'd6, 5'd2, 40);

    wait_drained();
    $display("Covered %0d requests and %0d replies: %0d computes, %0d flagged indices,",
             request_count, reply_count, compute_count, range_error_count);
    $display("count settings from one to sixteen with clamped and zero raw values.");
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
